@@ design/lfr_pkg.sv @@
// lfr_pkg: shared constants, opcodes and link memory port types
// for the lru frame replacer; no dependencies
`default_nettype none

package lfr_pkg;

   localparam int NUM_FRAMES  = 64;
   localparam int FRAME_W     = 6;
   localparam int COUNT_W     = 7;
   localparam int FRAME_SLOTS = 2 ** FRAME_W;

   typedef enum logic [1:0] {
      OP_VICTIM = 2'd0,
      OP_PIN    = 2'd1,
      OP_UNPIN  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic               en;
      logic [FRAME_W-1:0] addr;
   } link_rd_type;

   typedef struct packed {
      logic               en;
      logic [FRAME_W-1:0] addr;
      logic [FRAME_W-1:0] data;
   } link_wr_type;

   function automatic logic in_range(input logic [FRAME_W-1:0] f);
      in_range = (32'(f) < NUM_FRAMES);
   endfunction

endpackage

`default_nettype wire

@@ design/lru_frame_replacer_core.sv @@
// lru_frame_replacer_core: least recently unpinned frame replacer, top level
// depends on lfr_pkg and lfr_link_ram
// a request accepted in ST_IDLE moves to ST_UPDATE, which registers the result and its strobe
// a new request is taken only back in ST_IDLE, after the link memory read and write-back
// busy is high while in ST_UPDATE and low while the result is shown
// reset: synchronous; clears member flags, head, tail and count at once, no clearing pass
`default_nettype none

module lru_frame_replacer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [lfr_pkg::FRAME_W-1:0]   req_frame_number,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [lfr_pkg::FRAME_W-1:0]        rsp_victim_frame,
   output logic [lfr_pkg::COUNT_W-1:0]        rsp_tracked_count
);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff;

   // request held for the update cycle
   logic [1:0]                  op_ff;
   logic [lfr_pkg::FRAME_W-1:0] frame_ff;

   // list anchors and membership
   logic [lfr_pkg::FRAME_W-1:0]     head_ff, head_in;
   logic [lfr_pkg::FRAME_W-1:0]     tail_ff, tail_in;
   logic [lfr_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [lfr_pkg::FRAME_SLOTS-1:0] member_ff, member_in;

   // result registers
   logic                        rsp_valid_ff;
   logic                        found_ff, found_in;
   logic [lfr_pkg::FRAME_W-1:0] victim_ff, victim_in;
   logic [lfr_pkg::COUNT_W-1:0] tracked_ff;

   logic accept;

   lfr_pkg::link_rd_type        link_rd;
   lfr_pkg::link_wr_type        next_wr, prev_wr;
   logic [lfr_pkg::FRAME_W-1:0] younger, older;

   logic                        is_victim, is_pin, is_unpin;
   logic                        frame_ok, member_hit;
   logic                        do_unlink, do_append;
   logic [lfr_pkg::FRAME_W-1:0] target;

   // reset holds off requests as well
   assign busy   = (state_ff != ST_IDLE) | reset;
   assign accept = start & ~busy;

   // victim reads the links of the head, pin and unpin those of the named frame
   always_comb begin
      link_rd.en   = accept;
      link_rd.addr = (req_opcode == lfr_pkg::OP_VICTIM) ? head_ff : req_frame_number;
   end

   // next_link: toward younger frames
   lfr_link_ram u_next_ram (
      .clock   (clock),
      .rd      (link_rd),
      .wr      (next_wr),
      .rd_data (younger)
   );

   // prev_link: toward older frames
   lfr_link_ram u_prev_ram (
      .clock   (clock),
      .rd      (link_rd),
      .wr      (prev_wr),
      .rd_data (older)
   );

   // decode of the held request
   assign is_victim  = (op_ff == lfr_pkg::OP_VICTIM);
   assign is_pin     = (op_ff == lfr_pkg::OP_PIN);
   assign is_unpin   = (op_ff == lfr_pkg::OP_UNPIN);
   assign frame_ok   = lfr_pkg::in_range(frame_ff);
   assign member_hit = member_ff[frame_ff];

   // empty victim and out-of-range frames fall through with no change
   assign do_unlink = (state_ff == ST_UPDATE) &&
                      ((is_victim && (count_ff != '0)) || (is_pin && frame_ok && member_hit));
   assign do_append = (state_ff == ST_UPDATE) && is_unpin && frame_ok && !member_hit;
   assign target    = is_victim ? head_ff : frame_ff;

   // list update: at most one write to each link memory
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      member_in = member_ff;
      next_wr   = '0;
      prev_wr   = '0;

      if (do_unlink) begin
         if (count_ff <= lfr_pkg::COUNT_W'(1)) begin
            // last frame leaves, list empties
            head_in = '0;
            tail_in = '0;
         end else begin
            if (target == head_ff) begin
               head_in = younger;
            end else if (lfr_pkg::in_range(older)) begin
               next_wr.en   = 1'b1;
               next_wr.addr = older;
               next_wr.data = younger;
            end
            if (target == tail_ff) begin
               tail_in = older;
            end else if (lfr_pkg::in_range(younger)) begin
               prev_wr.en   = 1'b1;
               prev_wr.addr = younger;
               prev_wr.data = older;
            end
         end
         member_in[target] = 1'b0;
         count_in          = count_ff - lfr_pkg::COUNT_W'(1);
      end else if (do_append) begin
         if (count_ff == '0) begin
            head_in = frame_ff;
            tail_in = frame_ff;
         end else begin
            // hook behind the current tail
            if (lfr_pkg::in_range(tail_ff)) begin
               next_wr.en   = 1'b1;
               next_wr.addr = tail_ff;
               next_wr.data = frame_ff;
            end
            prev_wr.en   = 1'b1;
            prev_wr.addr = frame_ff;
            prev_wr.data = tail_ff;
            tail_in      = frame_ff;
         end
         member_in[frame_ff] = 1'b1;
         count_in            = count_ff + lfr_pkg::COUNT_W'(1);
      end
   end

   // result fields, victim frame forced to zero when nothing is evicted
   always_comb begin
      found_in  = is_victim && (count_ff != '0);
      victim_in = found_in ? head_ff : '0;
   end

   // control state, list anchors, membership and registered result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         member_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               rsp_valid_ff <= 1'b1;
               head_ff      <= head_in;
               tail_ff      <= tail_in;
               count_ff     <= count_in;
               member_ff    <= member_in;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         frame_ff <= req_frame_number;
      end
      if (state_ff == ST_UPDATE) begin
         found_ff   <= found_in;
         victim_ff  <= victim_in;
         tracked_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_victim_frame  = victim_ff;
   assign rsp_tracked_count = tracked_ff;

endmodule

`default_nettype wire

@@ design/lfr_link_ram.sv @@
// lfr_link_ram: one-read one-write link memory, registered read data
// depends on lfr_pkg
`default_nettype none

module lfr_link_ram (
   input  wire logic                        clock,
   input  wire lfr_pkg::link_rd_type        rd,
   input  wire lfr_pkg::link_wr_type        wr,
   output logic [lfr_pkg::FRAME_W-1:0]      rd_data
);

   logic [lfr_pkg::FRAME_W-1:0] mem [lfr_pkg::FRAME_SLOTS];
   logic [lfr_pkg::FRAME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/lfr_checker.sv @@
// lfr_checker: port-level checks of the frame replacer, bound to the top level
// depends on lfr_pkg and lru_frame_replacer_core
`default_nettype none

module lfr_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_found,
   input wire logic [lfr_pkg::FRAME_W-1:0] rsp_victim_frame,
   input wire logic [lfr_pkg::COUNT_W-1:0] rsp_tracked_count
);

   // each accepted request sees busy with no strobe, then its result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid) ##1 rsp_valid)
      else $error("result strobe missing after accepted request");

   // a result is only shown while idle
   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // no back to back strobes
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_no_victim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_victim_frame == '0))
      else $error("victim frame nonzero without eviction");

   // an eviction leaves fewer than all frames tracked
   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_tracked_count < lfr_pkg::COUNT_W'(lfr_pkg::FRAME_SLOTS)))
      else $error("tracked count too large after eviction");

endmodule

bind lru_frame_replacer_core lfr_checker u_lfr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_found         (rsp_found),
   .rsp_victim_frame  (rsp_victim_frame),
   .rsp_tracked_count (rsp_tracked_count)
);

`default_nettype wire

@@ bench/lru_frame_replacer_core_test.sv @@
// lru_frame_replacer_core_test: self-checking bench for the lru frame replacer core
// drives victim, pin and unpin requests and checks each result against a linked list predictor
// depends on lfr_pkg and lru_frame_replacer_core
`timescale 1ns / 1ps

module lru_frame_replacer_core_test;

   // opcode 3 is not decoded by the block but fits the port
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [1:0]                  opcode;
      logic [lfr_pkg::FRAME_W-1:0] frame;
      int                          gap;
   } request_item_type;

   typedef struct {
      logic                        found;
      logic [lfr_pkg::FRAME_W-1:0] victim;
      logic [lfr_pkg::COUNT_W-1:0] count;
   } replace_result_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_opcode;
   logic [lfr_pkg::FRAME_W-1:0]  req_frame_number;
   logic                         rsp_valid;
   logic                         rsp_found;
   logic [lfr_pkg::FRAME_W-1:0]  rsp_victim_frame;
   logic [lfr_pkg::COUNT_W-1:0]  rsp_tracked_count;

   lru_frame_replacer_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_frame_number  (req_frame_number),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_victim_frame  (rsp_victim_frame),
      .rsp_tracked_count (rsp_tracked_count)
   );

   // request stream and expected results
   request_item_type   pending_requests[$];
   replace_result_type expected_results[$];
   int                 fail_count = 0;
   int                 cycle_count = 0;

   // predictor state: doubly linked list of evictable frames, oldest at the front
   logic                        frame_tracked [lfr_pkg::NUM_FRAMES];
   logic [lfr_pkg::FRAME_W-1:0] younger_link  [lfr_pkg::NUM_FRAMES];
   logic [lfr_pkg::FRAME_W-1:0] older_link    [lfr_pkg::NUM_FRAMES];
   logic [lfr_pkg::FRAME_W-1:0] oldest_frame;
   logic [lfr_pkg::FRAME_W-1:0] youngest_frame;
   logic [lfr_pkg::COUNT_W-1:0] tracked_total;

   // driver state
   logic             took;
   request_item_type staged;
   logic             have_staged;
   int               wait_left;

   // clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // take a tracked frame out of the list, patching its neighbours
   task automatic drop_frame(input logic [lfr_pkg::FRAME_W-1:0] f);
      logic [lfr_pkg::FRAME_W-1:0] older;
      logic [lfr_pkg::FRAME_W-1:0] younger;
      older   = older_link[f];
      younger = younger_link[f];
      if (tracked_total <= 1) begin
         oldest_frame   = '0;
         youngest_frame = '0;
      end else begin
         if (f == oldest_frame) begin
            oldest_frame = younger;
         end else begin
            younger_link[older] = younger;
         end
         if (f == youngest_frame) begin
            youngest_frame = older;
         end else begin
            older_link[younger] = older;
         end
      end
      frame_tracked[f] = 1'b0;
      if (tracked_total > 0) tracked_total = tracked_total - lfr_pkg::COUNT_W'(1);
   endtask

   // put an untracked frame at the young end
   task automatic append_young(input logic [lfr_pkg::FRAME_W-1:0] f);
      if (tracked_total == 0) begin
         oldest_frame   = f;
         youngest_frame = f;
      end else begin
         younger_link[youngest_frame] = f;
         older_link[f]  = youngest_frame;
         youngest_frame = f;
      end
      frame_tracked[f] = 1'b1;
      tracked_total    = tracked_total + lfr_pkg::COUNT_W'(1);
   endtask

   // apply one accepted request and return what the block should report
   task automatic predict_replacement(input request_item_type r,
                                      output replace_result_type res);
      res.found  = 1'b0;
      res.victim = '0;
      unique case (r.opcode)
         lfr_pkg::OP_VICTIM: begin
            if (tracked_total > 0) begin
               res.found  = 1'b1;
               res.victim = oldest_frame;
               drop_frame(oldest_frame);
            end
         end
         lfr_pkg::OP_PIN: begin
            if (frame_tracked[r.frame]) drop_frame(r.frame);
         end
         lfr_pkg::OP_UNPIN: begin
            if (!frame_tracked[r.frame]) append_young(r.frame);
         end
         default: begin
            // unused opcode leaves everything alone
         end
      endcase
      res.count = tracked_total;
   endtask

   task automatic queue_request(input logic [1:0] op, input int f, input logic no_gaps);
      request_item_type r;
      r.opcode = op;
      r.frame  = f[lfr_pkg::FRAME_W-1:0];
      r.gap    = no_gaps ? 0 : $urandom_range(0, 4);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // opcode picked from per-mode weights out of 100
   function automatic logic [1:0] pick_opcode(input int unpin_w, input int pin_w,
                                              input int victim_w);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < unpin_w) return lfr_pkg::OP_UNPIN;
      if (roll < unpin_w + pin_w) return lfr_pkg::OP_PIN;
      if (roll < unpin_w + pin_w + victim_w) return lfr_pkg::OP_VICTIM;
      return OP_UNUSED;
   endfunction

   task automatic build_directed();
      queue_request(lfr_pkg::OP_VICTIM, 0, 1'b0);   // victim on an empty set
      queue_request(OP_UNUSED, 0, 1'b0);
      queue_request(lfr_pkg::OP_PIN, 0, 1'b0);      // pin of a frame not tracked
      queue_request(lfr_pkg::OP_UNPIN, 0, 1'b0);
      queue_request(lfr_pkg::OP_UNPIN, 63, 1'b0);
      queue_request(lfr_pkg::OP_UNPIN, 0, 1'b0);    // already tracked, keeps its place
      queue_request(lfr_pkg::OP_UNPIN, 42, 1'b0);
      queue_request(lfr_pkg::OP_UNPIN, 21, 1'b0);
      queue_request(lfr_pkg::OP_PIN, 63, 1'b0);     // pin from the middle
      queue_request(lfr_pkg::OP_VICTIM, 0, 1'b0);
      queue_request(lfr_pkg::OP_PIN, 21, 1'b0);     // pin of the youngest
      queue_request(lfr_pkg::OP_UNPIN, 63, 1'b0);
      queue_request(lfr_pkg::OP_PIN, 42, 1'b0);     // pin of the oldest
      queue_request(lfr_pkg::OP_VICTIM, 0, 1'b0);
      queue_request(lfr_pkg::OP_VICTIM, 0, 1'b0);
      queue_request(lfr_pkg::OP_UNPIN, 7, 1'b0);
      queue_request(lfr_pkg::OP_PIN, 7, 1'b0);      // pin of the only frame
      queue_request(OP_UNUSED, 63, 1'b0);
      queue_request(lfr_pkg::OP_UNPIN, 56, 1'b0);
      queue_request(lfr_pkg::OP_VICTIM, 63, 1'b0);  // frame field ignored on victim
      queue_request(lfr_pkg::OP_VICTIM, 0, 1'b0);
   endtask

   task automatic build_random(input int total);
      int made;
      int mode;
      int n;
      int i;
      int j;
      int tmp;
      int perm[lfr_pkg::NUM_FRAMES];
      logic no_gaps;
      made = 0;
      while (made < total) begin
         mode    = $urandom_range(0, 4);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (mode == 4) begin
            // unpin every frame in shuffled order, fills the set to the top
            for (i = 0; i < lfr_pkg::NUM_FRAMES; i++) perm[i] = i;
            for (i = lfr_pkg::NUM_FRAMES - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
            end
            for (i = 0; i < lfr_pkg::NUM_FRAMES; i++) begin
               queue_request(lfr_pkg::OP_UNPIN, perm[i], no_gaps);
            end
            made += lfr_pkg::NUM_FRAMES;
         end else begin
            n = $urandom_range(20, 60);
            for (i = 0; i < n; i++) begin
               unique case (mode)
                  0: queue_request(pick_opcode(75, 12, 11), $urandom_range(0, 63), no_gaps);
                  1: queue_request(pick_opcode(15, 20, 63), $urandom_range(0, 63), no_gaps);
                  2: queue_request(pick_opcode(40, 35, 23), $urandom_range(0, 63), no_gaps);
                  // few distinct frames, so pins and unpins collide often
                  default: queue_request(pick_opcode(45, 40, 13), $urandom_range(0, 7) * 9,
                                         no_gaps);
               endcase
            end
            made += n;
         end
      end
   endtask

   // driver: presents requests at the falling edge, holds while busy
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took) begin
         // request still waiting to be taken
      end else begin
         if (!have_staged && pending_requests.size() > 0) begin
            staged = pending_requests[0];
            pending_requests.delete(0);
            have_staged = 1'b1;
            wait_left   = staged.gap;
         end
         if (have_staged && wait_left == 0) begin
            start            <= 1'b1;
            req_opcode       <= staged.opcode;
            req_frame_number <= staged.frame;
            have_staged       = 1'b0;
         end else begin
            start <= 1'b0;
            if (have_staged) wait_left = wait_left - 1;
         end
      end
   end

   // monitor: predict on accept, check each result strobe
   always @(posedge clock) begin
      request_item_type   accepted;
      replace_result_type got;
      replace_result_type want;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (start && !busy) begin
            accepted.opcode = req_opcode;
            accepted.frame  = req_frame_number;
            accepted.gap    = 0;
            predict_replacement(accepted, want);
            expected_results.insert(expected_results.size(), want);
         end
         if (rsp_valid) begin
            got.found  = rsp_found;
            got.victim = rsp_victim_frame;
            got.count  = rsp_tracked_count;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result found %0b victim %0d count %0d",
                        $time, got.found, got.victim, got.count);
               fail_count++;
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (got.found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
                  fail_count++;
               end
               if (got.victim !== want.victim) begin
                  $display("%0t: victim_frame expected %0d actual %0d",
                           $time, want.victim, got.victim);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: tracked_count expected %0d actual %0d",
                           $time, want.count, got.count);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = lfr_pkg::OP_VICTIM;
      req_frame_number = '0;
      took             = 1'b0;
      have_staged      = 1'b0;
      wait_left        = 0;
      oldest_frame     = '0;
      youngest_frame   = '0;
      tracked_total    = '0;
      for (int i = 0; i < lfr_pkg::NUM_FRAMES; i++) begin
         frame_tracked[i] = 1'b0;
         younger_link[i]  = '0;
         older_link[i]    = '0;
      end
      build_directed();
      build_random(1000);

      // reset held, then released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests taken and every result seen
      while (pending_requests.size() > 0 || have_staged || start ||
             expected_results.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ lru_frame_replacer_core.f @@
design/lfr_pkg.sv
design/lfr_link_ram.sv
design/lru_frame_replacer_core.sv
design/lfr_checker.sv
bench/lru_frame_replacer_core_test.sv
